// ----- hdl/spq_sched_pkg.sv -----
// Package for the strict-priority queue scheduler: sizes, widths, codes
// and the FIFO storage address helper. No dependencies.
package spq_sched_pkg;

  // Sizing of the scheduler
  localparam int NUM_PORTS  = 8;
  localparam int NUM_LEVELS = 8;
  localparam int NUM_QUEUES = 16;
  localparam int FIFO_DEPTH = 16;

  // Fixed field widths of a beat
  localparam int PORT_FW = 3;
  localparam int QID_FW  = 4;
  localparam int PRIO_FW = 3;

  // Derived widths
  localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int LVL_W     = $clog2(NUM_LEVELS);
  localparam int QID_W     = $clog2(NUM_QUEUES);
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_PORTS * NUM_LEVELS * FIFO_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Configuration register indexes
  localparam logic REG_DEFAULT_PRIO = 1'b0;
  localparam logic REG_MAX_PRIO     = 1'b1;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_INSERT = 2'd1,
    OP_DROP   = 2'd2,
    OP_NEXT   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Flat storage address of slot ptr in the FIFO of (port, level)
  function automatic logic [ADDR_W-1:0] fifo_addr(input logic [PORT_W-1:0] port,
                                                  input logic [LVL_W-1:0]  lvl,
                                                  input logic [PTR_W-1:0]  ptr);
    return ADDR_W'((int'(port) * NUM_LEVELS + int'(lvl)) * FIFO_DEPTH + int'(ptr));
  endfunction

endpackage

// ----- hdl/strict_priority_queue_scheduler.sv -----
// Strict-priority queue scheduler: per-port FIFOs of queue ids per level.
// An accepted input beat passes the input register, then the result register
// with the registered storage read. Throughput: one beat per cycle unless
// m_axis_tready stalls the result; the per-port count/head row and the single
// storage port are touched once per beat. No clearing pass: reset clears
// config, queue levels, FIFO counts and heads at once; storage is not reset.
module strict_priority_queue_scheduler
  import spq_sched_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] port, [6:3] queue_id, [9:7] configured_priority,
  // [10] has_configured, [15:11] zero
  input  logic [15:0] s_axis_tdata,
  // [1:0] op
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] found, [4:1] next_queue, [6:5] status, [7] zero
  output logic [7:0]  m_axis_tdata
);

  // Configuration
  logic [PRIO_FW-1:0] def_prio_q, max_prio_q;

  // Input stage
  logic               s1_valid_q;
  op_e                op_q;
  logic [PORT_FW-1:0] port_q;
  logic [QID_FW-1:0]  qid_q;
  logic [PRIO_FW-1:0] cprio_q;
  logic               hascfg_q;

  // Scheduler state
  logic [LVL_W-1:0]  qlevel_q [NUM_QUEUES];
  logic [CNT_W-1:0]  cnt_q    [NUM_PORTS][NUM_LEVELS];
  logic [PTR_W-1:0]  head_q   [NUM_PORTS][NUM_LEVELS];
  logic [QID_FW-1:0] mem_q    [MEM_DEPTH];

  // Result stage
  logic              out_valid_q;
  logic              found_q;
  status_e           status_q;
  logic [QID_FW-1:0] rdata_q;

  // Datapath
  logic               adv, fire;
  logic               port_ok, q_ok;
  logic [PORT_W-1:0]  p_idx;
  logic [QID_W-1:0]   q_idx;
  logic [PRIO_FW-1:0] prio, lvl_full;
  logic [LVL_W-1:0]   crt_lvl, q_lvl, nxt_lvl, upd_lvl;
  logic               nxt_any;
  logic [CNT_W-1:0]   sel_cnt, nxt_cnt, cnt_d;
  logic [PTR_W-1:0]   sel_head, nxt_head, head_d, ins_ptr;
  logic [CNT_W:0]     ins_sum;
  logic [PTR_W:0]     head_inc;
  logic               lvl_we, upd_cnt, upd_head, mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_addr;
  logic               found_d;
  status_e            status_d;

  assign adv           = !out_valid_q || m_axis_tready;
  assign fire          = s1_valid_q && adv;
  assign s_axis_tready = !s1_valid_q || adv;

  always_comb begin
    port_ok = int'(port_q) < NUM_PORTS;
    q_ok    = int'(qid_q) < NUM_QUEUES;
    p_idx   = PORT_W'(port_q);
    q_idx   = QID_W'(qid_q);

    // Service level of a created queue, clamped both ways
    prio     = hascfg_q ? cprio_q : def_prio_q;
    lvl_full = (prio >= max_prio_q) ? '0 : max_prio_q - prio;
    if (int'(lvl_full) > NUM_LEVELS - 1) begin
      crt_lvl = LVL_W'(NUM_LEVELS - 1);
    end else begin
      crt_lvl = LVL_W'(lvl_full);
    end

    q_lvl    = qlevel_q[q_idx];
    sel_cnt  = cnt_q[p_idx][q_lvl];
    sel_head = head_q[p_idx][q_lvl];
    ins_sum  = (CNT_W+1)'(sel_head) + (CNT_W+1)'(sel_cnt);
    if (ins_sum >= (CNT_W+1)'(FIFO_DEPTH)) begin
      ins_ptr = PTR_W'(ins_sum - (CNT_W+1)'(FIFO_DEPTH));
    end else begin
      ins_ptr = PTR_W'(ins_sum);
    end

    // Lowest nonempty level of the port
    nxt_any = 1'b0;
    nxt_lvl = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (cnt_q[p_idx][l] != '0) begin
        nxt_any = 1'b1;
        nxt_lvl = LVL_W'(l);
      end
    end
    nxt_cnt  = cnt_q[p_idx][nxt_lvl];
    nxt_head = head_q[p_idx][nxt_lvl];
    head_inc = (PTR_W+1)'(nxt_head) + (PTR_W+1)'(1);

    lvl_we   = 1'b0;
    upd_cnt  = 1'b0;
    upd_head = 1'b0;
    upd_lvl  = q_lvl;
    cnt_d    = sel_cnt;
    head_d   = sel_head;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = fifo_addr(p_idx, q_lvl, ins_ptr);
    found_d  = 1'b0;
    status_d = ST_OK;

    unique case (op_q)
      OP_CREATE: begin
        lvl_we = q_ok;
      end
      OP_INSERT: begin
        if (!port_ok || !q_ok || int'(sel_cnt) >= FIFO_DEPTH) begin
          status_d = ST_FULL;
        end else begin
          mem_we  = 1'b1;
          upd_cnt = 1'b1;
          cnt_d   = sel_cnt + CNT_W'(1);
        end
      end
      OP_DROP: begin
        if (!port_ok || !q_ok || sel_cnt == '0) begin
          status_d = ST_EMPTY;
        end else begin
          upd_cnt = 1'b1;
          cnt_d   = sel_cnt - CNT_W'(1);
        end
      end
      OP_NEXT: begin
        if (port_ok && nxt_any) begin
          found_d  = 1'b1;
          mem_re   = 1'b1;
          mem_addr = fifo_addr(p_idx, nxt_lvl, nxt_head);
          upd_cnt  = 1'b1;
          upd_head = 1'b1;
          upd_lvl  = nxt_lvl;
          cnt_d    = nxt_cnt - CNT_W'(1);
          head_d   = (head_inc == (PTR_W+1)'(FIFO_DEPTH)) ? '0 : PTR_W'(head_inc);
        end else begin
          status_d = ST_EMPTY;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // Control and state with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_prio_q  <= '0;
      max_prio_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        qlevel_q[q] <= '0;
      end
      for (int p = 0; p < NUM_PORTS; p++) begin
        for (int l = 0; l < NUM_LEVELS; l++) begin
          cnt_q[p][l]  <= '0;
          head_q[p][l] <= '0;
        end
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DEFAULT_PRIO: def_prio_q <= cfg_wdata_i;
          REG_MAX_PRIO:     max_prio_q <= cfg_wdata_i;
          default:          max_prio_q <= max_prio_q;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        s1_valid_q <= 1'b1;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (fire && lvl_we) begin
        qlevel_q[q_idx] <= crt_lvl;
      end
      if (fire && upd_cnt) begin
        cnt_q[p_idx][upd_lvl] <= cnt_d;
      end
      if (fire && upd_head) begin
        head_q[p_idx][upd_lvl] <= head_d;
      end
    end
  end

  // Payload registers and storage, no reset
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q     <= op_e'(s_axis_tuser);
      port_q   <= s_axis_tdata[2:0];
      qid_q    <= s_axis_tdata[6:3];
      cprio_q  <= s_axis_tdata[9:7];
      hascfg_q <= s_axis_tdata[10];
    end
    if (fire) begin
      found_q  <= found_d;
      status_q <= status_d;
    end
    if (fire && mem_we) begin
      mem_q[mem_addr] <= qid_q;
    end
    if (fire && mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, status_q, (found_q ? rdata_q : '0), found_q};

  // Checks
  a_stage_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q)
    else $error("input stage beat lost while result stalled");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && found_q |-> status_q == ST_OK)
    else $error("found result carries error status");

  a_found_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && found_d |=> out_valid_q && found_q)
    else $error("popped entry not delivered as result");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> int'(sel_cnt) <= FIFO_DEPTH)
    else $error("FIFO count beyond depth");

endmodule

// ----- tb/testbench.sv -----
// Testbench for strict_priority_queue_scheduler: a scoreboard class keeps a
// shadow of the per-port level FIFOs and checks every result beat in order.
// Depends on spq_sched_pkg and the scheduler RTL only.
`timescale 1ns / 100ps

import spq_sched_pkg::*;

typedef struct packed {
  status_e        status;
  logic [QID_W-1:0] next_queue;
  logic           found;
} sched_result_t;

class sched_scoreboard;
  logic [2:0]       dflt_prio;
  logic [2:0]       max_prio;
  int unsigned      level_of [NUM_QUEUES];
  logic [QID_W-1:0] fifo_mem [NUM_PORTS*NUM_LEVELS][FIFO_DEPTH];
  int unsigned      fifo_rd  [NUM_PORTS*NUM_LEVELS];
  int unsigned      fifo_len [NUM_PORTS*NUM_LEVELS];
  sched_result_t    awaited_q[$];
  int errors, checked, n_served, n_full, n_empty, n_reg_writes;

  function new();
    dflt_prio = '0;
    max_prio  = '0;
    foreach (level_of[i]) level_of[i] = 0;
    foreach (fifo_rd[i]) begin
      fifo_rd[i]  = 0;
      fifo_len[i] = 0;
    end
    errors = 0; checked = 0; n_served = 0; n_full = 0; n_empty = 0; n_reg_writes = 0;
  endfunction

  function void set_register(logic idx, logic [2:0] val);
    if (idx == REG_DEFAULT_PRIO) dflt_prio = val;
    else max_prio = val;
    n_reg_writes++;
  endfunction

  function int pending();
    return awaited_q.size();
  endfunction

  // Shadow of one event: updates the tables and queues the result beat
  function void note_input(op_e op, logic [2:0] port, logic [3:0] qid,
                           logic [2:0] cprio, logic hascfg);
    sched_result_t r;
    int unsigned   prio, lvl, f;
    bit            port_ok, q_ok, served;
    r = '0;
    r.status = ST_OK;
    port_ok = int'(port) < NUM_PORTS;
    q_ok    = int'(qid) < NUM_QUEUES;
    served  = 1'b0;
    case (op)
      OP_CREATE: begin
        prio = hascfg ? 32'(cprio) : 32'(dflt_prio);
        lvl  = (prio >= 32'(max_prio)) ? 0 : 32'(max_prio) - prio;
        if (lvl > NUM_LEVELS - 1) lvl = NUM_LEVELS - 1;
        if (q_ok) level_of[qid] = lvl;
      end
      OP_INSERT, OP_DROP: begin
        if (!port_ok || !q_ok) begin
          r.status = (op == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end else begin
          f = port * NUM_LEVELS + level_of[qid];
          if (op == OP_INSERT) begin
            if (fifo_len[f] >= FIFO_DEPTH) begin
              r.status = ST_FULL;
            end else begin
              fifo_mem[f][(fifo_rd[f] + fifo_len[f]) % FIFO_DEPTH] = qid;
              fifo_len[f]++;
            end
          end else if (fifo_len[f] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            // newest entry goes, whatever id it holds
            fifo_len[f]--;
          end
        end
      end
      default: begin
        if (port_ok) begin
          for (int l = 0; l < NUM_LEVELS; l++) begin
            f = port * NUM_LEVELS + l;
            if (!served && fifo_len[f] != 0) begin
              r.found      = 1'b1;
              r.next_queue = fifo_mem[f][fifo_rd[f]];
              fifo_rd[f]   = (fifo_rd[f] + 1) % FIFO_DEPTH;
              fifo_len[f]--;
              served = 1'b1;
            end
          end
        end
        if (!served) r.status = ST_EMPTY;
      end
    endcase
    if (r.found) n_served++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    awaited_q.insert(awaited_q.size(), r);
  endfunction

  function void check_result(logic [7:0] beat);
    sched_result_t e;
    if (awaited_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: result beat %h with nothing awaited", beat);
      return;
    end
    e = awaited_q[0];
    awaited_q.delete(0);
    checked++;
    if (beat[0] !== e.found || beat[4:1] !== e.next_queue || beat[6:5] !== e.status) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: beat %0d: found %b/%b queue %0d/%0d status %0d/%0d (exp/got)",
                 checked, e.found, beat[0], e.next_queue, beat[4:1],
                 e.status, beat[6:5]);
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [2:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  sched_scoreboard sb = new();

  bit hold_req = 1'b0;
  int beats_sent = 0;
  int burst_left = 0;
  int stall_count = 0;

  strict_priority_queue_scheduler uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: segments of differing readiness, plus an on-demand long hold
  initial begin : rx_pattern
    int mode, seg_left, hold_left;
    seg_left = 0;
    hold_left = 0;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= seg_left[0];
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready)
      sb.check_result(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("ERROR: no beat moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  // Called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(op_e op, logic [2:0] port, logic [3:0] qid,
                           logic [2:0] cprio, logic hascfg);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {5'b0, hascfg, cprio, qid, port};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    sb.note_input(op, port, qid, cprio, hascfg);
    beats_sent++;
  endtask

  // Sender bursts: random gap before each new burst, sometimes none
  task automatic send_item(op_e op, logic [2:0] port, logic [3:0] qid,
                           logic [2:0] cprio, logic hascfg);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_beat(op, port, qid, cprio, hascfg);
  endtask

  task automatic drain_and_settle(logic [2:0] dflt, logic [2:0] maxp);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_DEFAULT_PRIO;
    cfg_wdata_i <= dflt;
    @(posedge clk_i);
    cfg_idx_i   <= REG_MAX_PRIO;
    cfg_wdata_i <= maxp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_register(REG_DEFAULT_PRIO, dflt);
    sb.set_register(REG_MAX_PRIO, maxp);
  endtask

  task automatic create_rand(logic [2:0] port, logic [3:0] qid);
    send_item(OP_CREATE, port, qid, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(int n_items, bit with_hold);
    logic [3:0] qs [6];
    logic [2:0] p;
    int k, m, kind, stop_at;
    bit held;
    stop_at = beats_sent + n_items;
    held = 1'b0;
    while (beats_sent < stop_at) begin
      if (with_hold && !held && beats_sent >= stop_at - n_items / 2) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      kind = $urandom_range(0, 9);
      p = 3'($urandom_range(0, 7));
      if (kind <= 5) begin
        // create a few queues, fill them, then serve the port
        k = $urandom_range(1, 6);
        for (int i = 0; i < k; i++) begin
          qs[i] = 4'($urandom_range(0, 15));
          create_rand(p, qs[i]);
        end
        m = $urandom_range(1, 12);
        for (int i = 0; i < m; i++) begin
          if ($urandom_range(0, 6) == 0)
            send_item(OP_DROP, p, qs[$urandom_range(0, k - 1)], 3'($urandom), 1'($urandom));
          else
            send_item(OP_INSERT, p, qs[$urandom_range(0, k - 1)], 3'($urandom), 1'($urandom));
        end
        repeat ($urandom_range(m / 2, m + 2))
          send_item(OP_NEXT, p, 4'($urandom), 3'($urandom), 1'($urandom));
      end else if (kind <= 7) begin
        // overfill one FIFO, then empty it past the bottom
        qs[0] = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) create_rand(p, qs[0]);
        repeat (FIFO_DEPTH + $urandom_range(0, 3))
          send_item(OP_INSERT, p, qs[0], 3'($urandom), 1'($urandom));
        repeat (FIFO_DEPTH + $urandom_range(0, 3)) begin
          if ($urandom_range(0, 2) == 0)
            send_item(OP_DROP, p, qs[0], 3'($urandom), 1'($urandom));
          else
            send_item(OP_NEXT, p, 4'($urandom), 3'($urandom), 1'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(op_e'($urandom_range(0, 3)), 3'($urandom), 4'($urandom),
                    3'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: clamp above max, default priority, deepest level, empties,
    // strict ordering across levels and drop of the newest entry
    drain_and_settle(3'd2, 3'd5);
    send_item(OP_CREATE, 3'd0, 4'd0,  3'd7, 1'b1);
    send_item(OP_CREATE, 3'd0, 4'd15, 3'd0, 1'b0);
    send_item(OP_CREATE, 3'd0, 4'd5,  3'd0, 1'b1);
    send_item(OP_NEXT,   3'd0, 4'd0,  3'd0, 1'b0);
    send_item(OP_DROP,   3'd0, 4'd0,  3'd0, 1'b0);
    send_item(OP_INSERT, 3'd7, 4'd5,  3'd7, 1'b1);
    send_item(OP_INSERT, 3'd7, 4'd15, 3'd7, 1'b1);
    send_item(OP_INSERT, 3'd7, 4'd0,  3'd7, 1'b1);
    repeat (4) send_item(OP_NEXT, 3'd7, 4'd15, 3'd7, 1'b1);
    send_item(OP_CREATE, 3'd2, 4'd1, 3'd4, 1'b1);
    send_item(OP_CREATE, 3'd2, 4'd2, 3'd4, 1'b1);
    send_item(OP_INSERT, 3'd2, 4'd1, 3'd0, 1'b0);
    send_item(OP_INSERT, 3'd2, 4'd2, 3'd0, 1'b0);
    send_item(OP_DROP,   3'd2, 4'd1, 3'd0, 1'b0);
    send_item(OP_NEXT,   3'd2, 4'd0, 3'd0, 1'b0);
    send_item(OP_NEXT,   3'd2, 4'd0, 3'd0, 1'b0);

    drain_and_settle(3'd0, 3'd0);
    run_phase(220, 1'b0);
    drain_and_settle(3'd0, 3'd7);
    run_phase(220, 1'b1);
    drain_and_settle(3'd7, 3'd7);
    run_phase(220, 1'b0);
    drain_and_settle(3'd7, 3'd0);
    run_phase(220, 1'b0);
    drain_and_settle(3'd3, 3'd6);
    run_phase(220, 1'b1);
    drain_and_settle(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    run_phase(220, 1'b0);
    drain_and_settle(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    run_phase(220, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d event beats under %0d register writes; %0d results checked.",
             beats_sent, sb.n_reg_writes, sb.checked);
    $display("Queues served: %0d, inserts refused full: %0d, empty reports: %0d.",
             sb.n_served, sb.n_full, sb.n_empty);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results still awaited", sb.errors, sb.pending());
      $display("Verification failed");
    end
    $finish;
  end
endmodule
